FILE: rtl/m3i_pkg.sv
// ----------------------------------------------------------------------------
// m3i_pkg: shared types and constants for the 3x3 matrix inverse core
// Request types for both channels, datapath widths and the divider stage record.
// ----------------------------------------------------------------------------
package m3i_pkg;

	localparam int DATA_WIDTH = 32;
	localparam int FRAC_BITS  = 16;

	// Derived datapath widths.
	localparam int PW = 2 * DATA_WIDTH;      // one element product
	localparam int AW = 2 * DATA_WIDTH + 1;  // adjugate element
	localparam int DW = 3 * DATA_WIDTH + 3;  // determinant, signed or as magnitude
	localparam int RW = DW + DATA_WIDTH;     // divider remainder

	typedef struct packed {
		logic signed [DATA_WIDTH-1:0] m_c0_r0;
		logic signed [DATA_WIDTH-1:0] m_c0_r1;
		logic signed [DATA_WIDTH-1:0] m_c0_r2;
		logic signed [DATA_WIDTH-1:0] m_c1_r0;
		logic signed [DATA_WIDTH-1:0] m_c1_r1;
		logic signed [DATA_WIDTH-1:0] m_c1_r2;
		logic signed [DATA_WIDTH-1:0] m_c2_r0;
		logic signed [DATA_WIDTH-1:0] m_c2_r1;
		logic signed [DATA_WIDTH-1:0] m_c2_r2;
	} m3i_in_t;

	typedef struct packed {
		logic signed [DATA_WIDTH-1:0] inv_c0_r0;
		logic signed [DATA_WIDTH-1:0] inv_c0_r1;
		logic signed [DATA_WIDTH-1:0] inv_c0_r2;
		logic signed [DATA_WIDTH-1:0] inv_c1_r0;
		logic signed [DATA_WIDTH-1:0] inv_c1_r1;
		logic signed [DATA_WIDTH-1:0] inv_c1_r2;
		logic signed [DATA_WIDTH-1:0] inv_c2_r0;
		logic signed [DATA_WIDTH-1:0] inv_c2_r1;
		logic signed [DATA_WIDTH-1:0] inv_c2_r2;
		logic                         singular;
		logic                         saturated;
	} m3i_out_t;

	// One lane of the long division: partial remainder, quotient so far,
	// result sign and the early overflow verdict.
	typedef struct packed {
		logic [RW-1:0]         rem;
		logic [DATA_WIDTH-1:0] quo;
		logic                  neg;
		logic                  ovf;
	} m3i_lane_t;

	typedef struct packed {
		m3i_lane_t [8:0] lane;
		logic [DW-1:0]   dmag;
		logic            singular;
	} m3i_div_t;

endpackage

FILE: rtl/m3i_div_stage.sv
// ----------------------------------------------------------------------------
// m3i_div_stage: one restoring division step for all nine lanes
// Resolves quotient bit BIT of every lane and registers the result.
// ----------------------------------------------------------------------------
module m3i_div_stage #(
	parameter int BIT = 0
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               src_valid,
	input  m3i_pkg::m3i_div_t  src,
	output logic               dst_valid,
	output m3i_pkg::m3i_div_t  dst
);

	localparam int RW = m3i_pkg::RW;
	localparam int DW = m3i_pkg::DW;

	logic [RW-1:0]     dsh;
	m3i_pkg::m3i_div_t nxt;

	assign dsh = {{(RW-DW){1'b0}}, src.dmag} << BIT;

	always_comb begin
		nxt = src;
		for (int k = 0; k < 9; k++) begin
			if (src.lane[k].rem >= dsh) begin
				nxt.lane[k].rem      = src.lane[k].rem - dsh;
				nxt.lane[k].quo[BIT] = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dst_valid <= 1'b0;
		end else if (en) begin
			dst_valid <= src_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en && src_valid) begin
			dst <= nxt;
		end
	end

endmodule

FILE: rtl/mat3_inverse_core.sv
// ----------------------------------------------------------------------------
// mat3_inverse_core: pipelined inverse of a signed fixed-point 3x3 matrix
// Adjugate by column cross products, determinant, then nine long divisions.
// ----------------------------------------------------------------------------
// The core accepts one matrix request per clock while mat_ready is high and
// returns one inverse per request, in order. A request passes through the
// element products, the adjugate, the split determinant products, the
// determinant sum, the magnitudes, the overflow check, the restoring divider
// chain and the saturating output register. Throughput is one matrix per
// cycle unless the output stalls. Every stage holds its request when the
// next stage is full, and empty stages close up, so a stall at the output
// loses nothing and the core keeps accepting while bubbles remain.
// A zero determinant gives all-zero elements with singular set; quotients
// truncate toward zero and clamp to the signed range, raising saturated.
module mat3_inverse_core #(
	parameter int FRAC_BITS = m3i_pkg::FRAC_BITS
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               mat_valid,
	output logic               mat_ready,
	input  m3i_pkg::m3i_in_t   mat,
	output logic               inv_valid,
	input  logic               inv_ready,
	output m3i_pkg::m3i_out_t  inv
);

	localparam int W  = m3i_pkg::DATA_WIDTH;
	localparam int PW = m3i_pkg::PW;
	localparam int AW = m3i_pkg::AW;
	localparam int DW = m3i_pkg::DW;
	localparam int RW = m3i_pkg::RW;

	// Elements in column-major order.
	logic signed [W-1:0] e [9];

	assign e[0] = mat.m_c0_r0;
	assign e[1] = mat.m_c0_r1;
	assign e[2] = mat.m_c0_r2;
	assign e[3] = mat.m_c1_r0;
	assign e[4] = mat.m_c1_r1;
	assign e[5] = mat.m_c1_r2;
	assign e[6] = mat.m_c2_r0;
	assign e[7] = mat.m_c2_r1;
	assign e[8] = mat.m_c2_r2;

	// Stage valids and advance enables.
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic en1, en2, en3, en4, en5, en6, en_out;
	logic          dv  [W];
	logic          den [W];
	m3i_pkg::m3i_div_t dd [W];

	assign en_out    = !inv_valid || inv_ready;
	assign en6       = !v_s6 || den[0];
	assign en5       = !v_s5 || en6;
	assign en4       = !v_s4 || en5;
	assign en3       = !v_s3 || en4;
	assign en2       = !v_s2 || en3;
	assign en1       = !v_s1 || en2;
	assign mat_ready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (en1) v_s1 <= mat_valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
			if (en5) v_s5 <= v_s4;
			if (en6) v_s6 <= v_s5;
		end
	end

	// Stage 1: the eighteen element products behind the adjugate. Adjugate
	// entry (row i, column j) is component j of the cross product of columns
	// i+1 and i+2, taken cyclically.
	logic signed [PW-1:0] pa_s1 [9];
	logic signed [PW-1:0] pb_s1 [9];
	logic signed [W-1:0]  e0_s1 [3];

	for (genvar i = 0; i < 3; i++) begin : g_adj_col
		for (genvar j = 0; j < 3; j++) begin : g_adj_row
			localparam int U = ((i + 1) % 3) * 3;
			localparam int V = ((i + 2) % 3) * 3;
			localparam int P = (j + 1) % 3;
			localparam int Q = (j + 2) % 3;
			always_ff @(posedge clk) begin
				if (en1 && mat_valid) begin
					pa_s1[j*3+i] <= e[U+P] * e[V+Q];
					pb_s1[j*3+i] <= e[U+Q] * e[V+P];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en1 && mat_valid) begin
			for (int j = 0; j < 3; j++) e0_s1[j] <= e[j];
		end
	end

	// Stage 2: adjugate entries.
	logic signed [AW-1:0] adj_s2 [9];
	logic signed [W-1:0]  e0_s2  [3];

	always_ff @(posedge clk) begin
		if (en2 && v_s1) begin
			for (int k = 0; k < 9; k++) begin
				adj_s2[k] <= $signed({pa_s1[k][PW-1], pa_s1[k]})
					- $signed({pb_s1[k][PW-1], pb_s1[k]});
			end
			for (int j = 0; j < 3; j++) e0_s2[j] <= e0_s1[j];
		end
	end

	// Stage 3: determinant terms, each split into a low and a high partial
	// product so that no multiplier is much wider than the element width.
	logic signed [AW-1:0] ppl_s3 [3];
	logic signed [AW-1:0] pph_s3 [3];
	logic signed [AW-1:0] adj_s3 [9];

	always_ff @(posedge clk) begin
		if (en3 && v_s2) begin
			for (int j = 0; j < 3; j++) begin
				ppl_s3[j] <= e0_s2[j] * $signed({1'b0, adj_s2[j*3][W-1:0]});
				pph_s3[j] <= e0_s2[j] * $signed(adj_s2[j*3][AW-1:W]);
			end
			for (int k = 0; k < 9; k++) adj_s3[k] <= adj_s2[k];
		end
	end

	// Stage 4: determinant as the sum of the three recombined terms.
	logic signed [DW-1:0] det_s4;
	logic signed [AW-1:0] adj_s4 [9];
	logic signed [DW-1:0] det_sum;

	always_comb begin
		det_sum = '0;
		for (int j = 0; j < 3; j++) begin
			det_sum = det_sum
				+ ($signed({{(DW-AW){pph_s3[j][AW-1]}}, pph_s3[j]}) <<< W)
				+ $signed({{(DW-AW){ppl_s3[j][AW-1]}}, ppl_s3[j]});
		end
	end

	always_ff @(posedge clk) begin
		if (en4 && v_s3) begin
			det_s4 <= det_sum;
			for (int k = 0; k < 9; k++) adj_s4[k] <= adj_s3[k];
		end
	end

	// Stage 5: magnitudes and result signs. The numerator carries the
	// double fractional scaling of the quotient.
	logic [RW-1:0] nmag_s5 [9];
	logic          neg_s5  [9];
	logic [DW-1:0] dmag_s5;
	logic          sing_s5;

	always_ff @(posedge clk) begin
		if (en5 && v_s4) begin
			for (int k = 0; k < 9; k++) begin
				nmag_s5[k] <= {{(RW-AW){1'b0}},
					(adj_s4[k][AW-1] ? (~adj_s4[k] + 1'b1) : adj_s4[k])}
					<< (2 * FRAC_BITS);
				neg_s5[k]  <= adj_s4[k][AW-1] ^ det_s4[DW-1];
			end
			dmag_s5 <= det_s4[DW-1] ? (~det_s4 + 1'b1) : det_s4;
			sing_s5 <= (det_s4 == '0);
		end
	end

	// Stage 6: a quotient of 2^W or more saturates whatever its low bits are,
	// so it is caught here and the divider only resolves W bits.
	m3i_pkg::m3i_div_t div_s6;

	always_ff @(posedge clk) begin
		if (en6 && v_s5) begin
			for (int k = 0; k < 9; k++) begin
				div_s6.lane[k].rem <= nmag_s5[k];
				div_s6.lane[k].quo <= '0;
				div_s6.lane[k].neg <= neg_s5[k];
				div_s6.lane[k].ovf <= (nmag_s5[k] >= {dmag_s5, {W{1'b0}}});
			end
			div_s6.dmag     <= dmag_s5;
			div_s6.singular <= sing_s5;
		end
	end

	// Divider chain, most significant quotient bit first.
	for (genvar t = 0; t < W; t++) begin : g_div
		if (t == W - 1) begin : g_last
			assign den[t] = !dv[t] || en_out;
		end else begin : g_mid
			assign den[t] = !dv[t] || den[t+1];
		end
		if (t == 0) begin : g_first
			m3i_div_stage #(.BIT(W - 1 - t)) u_stage (
				.clk       (clk),
				.arst_n    (arst_n),
				.en        (den[t]),
				.src_valid (v_s6),
				.src       (div_s6),
				.dst_valid (dv[t]),
				.dst       (dd[t])
			);
		end else begin : g_next
			m3i_div_stage #(.BIT(W - 1 - t)) u_stage (
				.clk       (clk),
				.arst_n    (arst_n),
				.en        (den[t]),
				.src_valid (dv[t-1]),
				.src       (dd[t-1]),
				.dst_valid (dv[t]),
				.dst       (dd[t])
			);
		end
	end

	// Output stage: sign, clamp and the singular override.
	m3i_pkg::m3i_div_t   fin;
	logic signed [W-1:0] res [9];
	logic                sat_any;
	localparam logic [W-1:0] MAXPOS = {1'b0, {(W-1){1'b1}}};
	localparam logic [W-1:0] MINNEG = {1'b1, {(W-1){1'b0}}};

	assign fin = dd[W-1];

	always_comb begin
		sat_any = 1'b0;
		for (int k = 0; k < 9; k++) begin
			res[k] = '0;
			if (!fin.singular) begin
				if (!fin.lane[k].neg) begin
					if (fin.lane[k].ovf || fin.lane[k].quo[W-1]) begin
						res[k]  = MAXPOS;
						sat_any = 1'b1;
					end else begin
						res[k] = fin.lane[k].quo;
					end
				end else begin
					if (fin.lane[k].ovf || (fin.lane[k].quo[W-1]
						&& (fin.lane[k].quo[W-2:0] != '0))) begin
						res[k]  = MINNEG;
						sat_any = 1'b1;
					end else begin
						res[k] = ~fin.lane[k].quo + 1'b1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inv_valid <= 1'b0;
		end else if (en_out) begin
			inv_valid <= dv[W-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en_out && dv[W-1]) begin
			inv.inv_c0_r0 <= res[0];
			inv.inv_c0_r1 <= res[1];
			inv.inv_c0_r2 <= res[2];
			inv.inv_c1_r0 <= res[3];
			inv.inv_c1_r1 <= res[4];
			inv.inv_c1_r2 <= res[5];
			inv.inv_c2_r0 <= res[6];
			inv.inv_c2_r1 <= res[7];
			inv.inv_c2_r2 <= res[8];
			inv.singular  <= fin.singular;
			inv.saturated <= sat_any;
		end
	end

	// A singular result never reports clamping and carries zero elements.
	a_singular_clean : assert property (@(posedge clk) disable iff (!arst_n)
		inv_valid && inv.singular |-> !inv.saturated && inv.inv_c0_r0 == '0
			&& inv.inv_c1_r1 == '0 && inv.inv_c2_r2 == '0)
		else $error("singular result with non-zero payload");

	// Requests are refused only when every stage is full and the output stalls.
	a_ready_full : assert property (@(posedge clk) disable iff (!arst_n)
		!mat_ready |-> inv_valid && !inv_ready && v_s1 && v_s6 && dv[W-1])
		else $error("request refused with room in the pipeline");

	// A stalled first stage keeps its request.
	a_s1_hold : assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && !en2 |=> v_s1)
		else $error("stalled first stage lost its request");

endmodule
